// ----- hdl/psl_pkg.sv -----
// ----------------------------------------------------------------------------
// psl_pkg: shared types and microcode for the prime sieve lister
// Field widths, sizes, control word layout and the control store contents.
// ----------------------------------------------------------------------------
package psl_pkg;

  localparam int LIMIT_W    = 9;
  localparam int PRIME_W    = 8;
  localparam int MAX_LIMIT  = 256;
  localparam int MAP_DEPTH  = MAX_LIMIT + 1;
  localparam int RESULT_CAP = 54;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);
  localparam int PC_W       = 4;

  typedef logic [LIMIT_W-1:0]   limit_t;
  typedef logic [PRIME_W-1:0]   prime_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [PC_W-1:0]      pc_t;
  typedef logic [2*LIMIT_W-1:0] square_t;

  // jump conditions; a true condition loads the target, else pc + 1
  typedef enum logic [3:0] {
    C_NEXT,     // never jump
    C_ALWAYS,
    C_NO_IN,    // no input transfer this cycle
    C_SMALL,    // n below two
    C_SQ_GT,    // p * p above n
    C_RD_ZERO,  // map bit read back is clear
    C_STEP_LE,  // idx + p still within n
    C_IDX_NE,   // idx has not reached n
    C_CAP       // prime found and result cap reached
  } cond_e;

  typedef enum logic [1:0] {WR_NONE, WR_FILL, WR_CLR} wr_e;
  typedef enum logic [1:0] {RD_NONE, RD_BASE, RD_IDX} rd_e;
  typedef enum logic [2:0] {IDX_HOLD, IDX_ZERO, IDX_INC, IDX_SQ, IDX_ADDP, IDX_TWO} idx_op_e;
  typedef enum logic [1:0] {BASE_HOLD, BASE_TWO, BASE_INC} base_op_e;
  typedef enum logic [1:0] {EM_NONE, EM_PEND, EM_LAST, EM_EMPTY} emit_e;

  typedef struct packed {
    cond_e    cond;
    pc_t      target;
    logic     in_rdy;
    wr_e      wr;
    rd_e      rd;
    idx_op_e  idx_op;
    base_op_e base_op;
    emit_e    emit;
    logic     capture;   // take a found prime into the pending slot
    logic     scan_clr;  // clear found count, so the pending slot counts as empty
  } cw_t;

  // step addresses
  localparam pc_t ST_IDLE  = pc_t'(0);
  localparam pc_t ST_CHK   = pc_t'(1);
  localparam pc_t ST_FILL  = pc_t'(2);
  localparam pc_t ST_BINIT = pc_t'(3);
  localparam pc_t ST_BTEST = pc_t'(4);
  localparam pc_t ST_BCHK  = pc_t'(5);
  localparam pc_t ST_MARK  = pc_t'(6);
  localparam pc_t ST_BNEXT = pc_t'(7);
  localparam pc_t ST_SINIT = pc_t'(8);
  localparam pc_t ST_SRD   = pc_t'(9);
  localparam pc_t ST_SCHK  = pc_t'(10);
  localparam pc_t ST_SNEXT = pc_t'(11);
  localparam pc_t ST_FINAL = pc_t'(12);
  localparam pc_t ST_EMPTY = pc_t'(13);

  localparam cw_t CW_NOP = '{cond: C_NEXT, target: ST_IDLE, in_rdy: 1'b0, wr: WR_NONE,
                             rd: RD_NONE, idx_op: IDX_HOLD, base_op: BASE_HOLD,
                             emit: EM_NONE, capture: 1'b0, scan_clr: 1'b0};

  function automatic cw_t ucode(pc_t pc);
    cw_t cw;
    cw = CW_NOP;
    case (pc)
      ST_IDLE: begin
        cw.in_rdy = 1'b1; cw.idx_op = IDX_ZERO;
        cw.cond = C_NO_IN; cw.target = ST_IDLE;
      end
      ST_CHK: begin
        cw.cond = C_SMALL; cw.target = ST_EMPTY;
      end
      ST_FILL: begin
        cw.wr = WR_FILL; cw.idx_op = IDX_INC;
        cw.cond = C_IDX_NE; cw.target = ST_FILL;
      end
      ST_BINIT: begin
        cw.base_op = BASE_TWO;
      end
      ST_BTEST: begin
        cw.rd = RD_BASE; cw.idx_op = IDX_SQ;
        cw.cond = C_SQ_GT; cw.target = ST_SINIT;
      end
      ST_BCHK: begin
        cw.cond = C_RD_ZERO; cw.target = ST_BNEXT;
      end
      ST_MARK: begin
        cw.wr = WR_CLR; cw.idx_op = IDX_ADDP;
        cw.cond = C_STEP_LE; cw.target = ST_MARK;
      end
      ST_BNEXT: begin
        cw.base_op = BASE_INC;
        cw.cond = C_ALWAYS; cw.target = ST_BTEST;
      end
      ST_SINIT: begin
        cw.idx_op = IDX_TWO; cw.scan_clr = 1'b1;
      end
      ST_SRD: begin
        cw.rd = RD_IDX;
      end
      ST_SCHK: begin
        cw.emit = EM_PEND; cw.capture = 1'b1;
        cw.cond = C_CAP; cw.target = ST_FINAL;
      end
      ST_SNEXT: begin
        cw.idx_op = IDX_INC;
        cw.cond = C_IDX_NE; cw.target = ST_SRD;
      end
      ST_FINAL: begin
        cw.emit = EM_LAST;
        cw.cond = C_ALWAYS; cw.target = ST_IDLE;
      end
      ST_EMPTY: begin
        cw.emit = EM_EMPTY;
        cw.cond = C_ALWAYS; cw.target = ST_IDLE;
      end
      default: begin
        cw.cond = C_ALWAYS; cw.target = ST_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

// ----- hdl/psl_in_if.sv -----
// ----------------------------------------------------------------------------
// psl_in_if: limit channel
// Valid/ready channel carrying one upper limit per transfer.
// ----------------------------------------------------------------------------
interface psl_in_if;
  logic            valid;
  logic            ready;
  psl_pkg::limit_t limit;

  modport source (output valid, output limit, input ready);
  modport sink   (input valid, input limit, output ready);
endinterface

// ----- hdl/psl_out_if.sv -----
// ----------------------------------------------------------------------------
// psl_out_if: prime result channel
// Valid/ready channel carrying one listed prime, or an empty result, per transfer.
// ----------------------------------------------------------------------------
interface psl_out_if;
  logic            valid;
  logic            ready;
  psl_pkg::prime_t prime_value;
  logic            valid_res;
  logic            last;

  modport source (output valid, output prime_value, output valid_res, output last,
                  input ready);
  modport sink   (input valid, input prime_value, input valid_res, input last,
                  output ready);
endinterface

// ----- hdl/prime_sieve_lister_unit.sv -----
// ----------------------------------------------------------------------------
// prime_sieve_lister_unit: microcoded sieve of Eratosthenes
// Lists all primes up to a given limit, in rising order, last one flagged.
// ----------------------------------------------------------------------------
// Flow: a limit below two gives one empty result flagged last. Otherwise map entries
// 0..n are filled, each base p with p*p <= n is read and, if still marked, its multiples
// from p*p up to n are cleared; then 2..n are scanned and every prime found is listed.
// One item at a time; a result step holds while the output register is still full.
// Reset (async, active low) returns the sequencer to idle and drops out valid;
// the map itself is not cleared, every item rewrites 0..n before reading.
// ----------------------------------------------------------------------------
module prime_sieve_lister_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  psl_in_if.sink        req_i,
  psl_out_if.source     res_o
);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  psl_pkg::pc_t    pc_q, pc_d;
  psl_pkg::cw_t    cw;

  // datapath registers
  psl_pkg::limit_t n_q;       // saturated limit
  psl_pkg::limit_t base_q;    // sieve base p
  psl_pkg::limit_t idx_q;     // map index (fill, multiples, scan)
  logic            rd_q;      // registered map read data
  psl_pkg::prime_t pend_q;    // prime held back until we know if it is the last
  psl_pkg::cnt_t   found_q;   // primes taken into the pending slot

  // output register
  logic            out_vld_q;
  psl_pkg::prime_t out_prime_q;
  logic            out_res_q;
  logic            out_last_q;

  logic            map_q [psl_pkg::MAP_DEPTH];

  logic            in_xfer;
  logic            emit_req;
  logic            stall;
  logic            adv;
  logic            jump;
  psl_pkg::square_t sq;
  psl_pkg::limit_t idx_step;
  psl_pkg::limit_t lim_sat;
  psl_pkg::limit_t rd_addr;
  logic            prime_hit;

  assign cw = psl_pkg::ucode(pc_q);

  assign req_i.ready = cw.in_rdy;
  assign in_xfer     = req_i.valid & cw.in_rdy;

  assign lim_sat = (req_i.limit > psl_pkg::limit_t'(psl_pkg::MAX_LIMIT)) ?
                   psl_pkg::limit_t'(psl_pkg::MAX_LIMIT) : req_i.limit;

  assign sq        = psl_pkg::square_t'(base_q) * psl_pkg::square_t'(base_q);
  assign idx_step  = idx_q + base_q;
  assign prime_hit = rd_q;

  // A result step waits while the output register still holds an untaken result
  always_comb begin
    case (cw.emit)
      psl_pkg::EM_PEND:  emit_req = prime_hit & (found_q != '0);
      psl_pkg::EM_LAST:  emit_req = 1'b1;
      psl_pkg::EM_EMPTY: emit_req = 1'b1;
      default:           emit_req = 1'b0;
    endcase
  end

  assign stall = emit_req & out_vld_q & ~res_o.ready;
  assign adv   = ~stall;

  always_comb begin
    case (cw.cond)
      psl_pkg::C_ALWAYS:  jump = 1'b1;
      psl_pkg::C_NO_IN:   jump = ~in_xfer;
      psl_pkg::C_SMALL:   jump = (n_q < psl_pkg::limit_t'(2));
      psl_pkg::C_SQ_GT:   jump = (sq > psl_pkg::square_t'(n_q));
      psl_pkg::C_RD_ZERO: jump = ~rd_q;
      psl_pkg::C_STEP_LE: jump = (idx_step <= n_q);
      psl_pkg::C_IDX_NE:  jump = (idx_q != n_q);
      psl_pkg::C_CAP:     jump = prime_hit &
                                 (found_q == psl_pkg::cnt_t'(psl_pkg::RESULT_CAP - 1));
      default:            jump = 1'b0;
    endcase
  end

  always_comb begin
    if (!adv) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = cw.target;
    end else begin
      pc_d = pc_q + psl_pkg::pc_t'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Control state and datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= psl_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
      found_q   <= '0;
      base_q    <= '0;
      idx_q     <= '0;
    end else begin
      pc_q <= pc_d;

      if (emit_req && adv) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end

      if (adv) begin
        case (cw.idx_op)
          psl_pkg::IDX_ZERO: idx_q <= '0;
          psl_pkg::IDX_INC:  idx_q <= idx_q + psl_pkg::limit_t'(1);
          psl_pkg::IDX_SQ:   idx_q <= sq[psl_pkg::LIMIT_W-1:0];
          psl_pkg::IDX_ADDP: idx_q <= idx_step;
          psl_pkg::IDX_TWO:  idx_q <= psl_pkg::limit_t'(2);
          default:           idx_q <= idx_q;
        endcase

        case (cw.base_op)
          psl_pkg::BASE_TWO: base_q <= psl_pkg::limit_t'(2);
          psl_pkg::BASE_INC: base_q <= base_q + psl_pkg::limit_t'(1);
          default:           base_q <= base_q;
        endcase

        if (cw.scan_clr) begin
          found_q <= '0;
        end else if (cw.capture && prime_hit) begin
          found_q <= found_q + psl_pkg::cnt_t'(1);
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      n_q <= lim_sat;
    end
    if (adv && cw.capture && prime_hit) begin
      pend_q <= idx_q[psl_pkg::PRIME_W-1:0];
    end
    if (emit_req && adv) begin
      case (cw.emit)
        psl_pkg::EM_PEND: begin
          out_prime_q <= pend_q;
          out_res_q   <= 1'b1;
          out_last_q  <= 1'b0;
        end
        psl_pkg::EM_LAST: begin
          out_prime_q <= pend_q;
          out_res_q   <= 1'b1;
          out_last_q  <= 1'b1;
        end
        default: begin
          out_prime_q <= '0;
          out_res_q   <= 1'b0;
          out_last_q  <= 1'b1;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Candidate map: one write or one registered read per cycle
  // --------------------------------------------------------------------------
  assign rd_addr = (cw.rd == psl_pkg::RD_BASE) ? base_q : idx_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      case (cw.wr)
        psl_pkg::WR_FILL: map_q[idx_q] <= (idx_q >= psl_pkg::limit_t'(2));
        psl_pkg::WR_CLR:  map_q[idx_q] <= 1'b0;
        default:          ;
      endcase
      if (cw.rd != psl_pkg::RD_NONE) begin
        rd_q <= map_q[rd_addr];
      end
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.prime_value = out_prime_q;
  assign res_o.valid_res   = out_res_q;
  assign res_o.last        = out_last_q;

endmodule
